// ===== rtl/core/tdcc_pkg.sv =====
// Shared types, constants and helpers for the tick-driven clock/calendar.
// No dependencies; imported by every module of the block.
package tdcc_pkg;

   localparam int DataWidth = 48;   // 42 field bits padded to whole bytes
   localparam int KindWidth = 2;
   localparam int TpsWidth  = 8;

   typedef enum logic [KindWidth-1:0] {
      REQ_TICK     = 2'd0,
      REQ_SET_TIME = 2'd1,
      REQ_SET_DATE = 2'd2
   } req_kind_type;

   // Field order matches tdata packing: hour in the lowest bits, year highest
   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
   } clock_state_type;

   localparam logic [5:0] SecondLast = 6'd59;
   localparam logic [5:0] MinuteLast = 6'd59;
   localparam logic [4:0] HourLast   = 5'd23;
   localparam logic [3:0] MonthLast  = 4'd12;
   localparam logic [3:0] MonthFirst = 4'd1;
   localparam logic [4:0] DayFirst   = 5'd1;

   localparam logic [TpsWidth-1:0] TpsReset = 8'd60;

   localparam clock_state_type ClockReset = '{
      year:   16'd0,
      month:  MonthFirst,
      day:    DayFirst,
      second: 6'd0,
      minute: 6'd0,
      hour:   5'd0
   };

   // last day of a month; unused month codes count as 31-day months
   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] len;
      case (month) inside
         4'd2:                   len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [DataWidth-1:0] pack_state(input clock_state_type st);
      return {{(DataWidth - $bits(clock_state_type)){1'b0}}, st};
   endfunction

   function automatic clock_state_type unpack_state(input logic [DataWidth-1:0] data);
      return clock_state_type'(data[$bits(clock_state_type)-1:0]);
   endfunction

endpackage

// ===== rtl/core/tick_driven_clock_calendar.sv =====
// Top level of the tick-driven clock/calendar: state registers, settings
// register, next-state logic and output buffer. Depends on tdcc_pkg,
// tdcc_next and tdcc_skid.
//
//  channel   direction  signals                                  one transfer
//  req       in         req_tvalid/tready, tdata[47:0], tuser    one request
//  rsp       out        rsp_tvalid/tready, tdata[47:0]           current time/date
//  csr       in         csr_we, csr_wdata[7:0]                   ticks per second
//
// One request per cycle while req_tready is high. The counters update at the
// request transfer and the response enters the result register, or the skid
// register while a response stalls, so the two-deep buffer still takes a
// request then; req_tready drops only once both entries hold responses.
// Synchronous reset: time 00:00:00, day 1, month 1, year 0, prescaler 0,
// 60 ticks per second; output buffer empty.
module tick_driven_clock_calendar (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // set_hour[4:0], set_minute[10:5], set_second[16:11], set_day[21:17],
   // set_month[25:22], set_year[41:26], zero [47:42]
   input  logic [tdcc_pkg::DataWidth-1:0]     req_tdata,
   // req_type[1:0]: tick, set time, set date
   input  logic [tdcc_pkg::KindWidth-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hour[4:0], minute[10:5], second[16:11], day[21:17], month[25:22],
   // year[41:26], zero [47:42]
   output logic [tdcc_pkg::DataWidth-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [tdcc_pkg::TpsWidth-1:0]      csr_wdata
);
   import tdcc_pkg::*;

   clock_state_type       clock_ff;
   clock_state_type       clock_in;
   logic [TpsWidth-1:0]   prescale_ff;
   logic [TpsWidth-1:0]   prescale_in;
   logic [TpsWidth-1:0]   tps_ff;
   logic                  push;

   assign push = req_tvalid && req_tready;

   // whole request decoded and applied in one combinational pass
   tdcc_next u_next (
      .cur_state        (clock_ff),
      .cur_prescale     (prescale_ff),
      .ticks_per_second (tps_ff),
      .req_kind         (req_tuser),
      .set_value        (unpack_state(req_tdata)),
      .nxt_state        (clock_in),
      .nxt_prescale     (prescale_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff    <= ClockReset;
         prescale_ff <= '0;
         tps_ff      <= TpsReset;
      end else begin
         if (push) begin
            clock_ff    <= clock_in;
            prescale_ff <= prescale_in;
         end
         if (csr_we) begin
            tps_ff <= csr_wdata;
         end
      end
   end

   // response carries the state after this request
   tdcc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (pack_state(clock_in)),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // a response is valid in the cycle after every accepted request
   a_push_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("no response after request transfer");

   // counters only move on a request transfer
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !push |=> ($stable(clock_ff) && $stable(prescale_ff)))
      else $error("time state changed without a request");

   // a set-time load lands hour and second exactly as given
   a_set_time_load: assert property (@(posedge clock) disable iff (reset)
      (push && req_tuser == REQ_SET_TIME) |=>
         (clock_ff.hour == $past(req_tdata[4:0])
          && clock_ff.second == $past(req_tdata[16:11])))
      else $error("set-time load mismatch");

endmodule

// ===== rtl/core/tdcc_next.sv =====
// Next-state logic for one request: prescaler, time/date carry chain, loads.
// Depends on tdcc_pkg.
module tdcc_next (
   input  tdcc_pkg::clock_state_type        cur_state,
   input  logic [tdcc_pkg::TpsWidth-1:0]    cur_prescale,
   input  logic [tdcc_pkg::TpsWidth-1:0]    ticks_per_second,
   input  logic [tdcc_pkg::KindWidth-1:0]   req_kind,
   input  tdcc_pkg::clock_state_type        set_value,
   output tdcc_pkg::clock_state_type        nxt_state,
   output logic [tdcc_pkg::TpsWidth-1:0]    nxt_prescale
);
   import tdcc_pkg::*;

   logic [TpsWidth:0] prescale_inc;

   assign prescale_inc = {1'b0, cur_prescale} + {{TpsWidth{1'b0}}, 1'b1};

   always_comb begin
      nxt_state    = cur_state;
      nxt_prescale = cur_prescale;
      unique case (req_kind)
         REQ_TICK: begin
            // a setting of zero acts as one: inc >= 0 always wraps
            if (prescale_inc >= {1'b0, ticks_per_second}) begin
               nxt_prescale = '0;
               if (cur_state.second < SecondLast) begin
                  nxt_state.second = cur_state.second + 6'd1;
               end else begin
                  nxt_state.second = '0;
                  if (cur_state.minute < MinuteLast) begin
                     nxt_state.minute = cur_state.minute + 6'd1;
                  end else begin
                     nxt_state.minute = '0;
                     if (cur_state.hour < HourLast) begin
                        nxt_state.hour = cur_state.hour + 5'd1;
                     end else begin
                        nxt_state.hour = '0;
                        if (cur_state.day >= month_length(cur_state.month)) begin
                           nxt_state.day   = DayFirst;
                           nxt_state.month = cur_state.month + 4'd1;
                        end else begin
                           nxt_state.day = cur_state.day + 5'd1;
                        end
                     end
                  end
               end
            end else begin
               nxt_prescale = prescale_inc[TpsWidth-1:0];
            end
            // month past December rolls the year on every tick
            if (nxt_state.month > MonthLast) begin
               nxt_state.month = MonthFirst;
               nxt_state.year  = cur_state.year + 16'd1;
            end
         end
         REQ_SET_TIME: begin
            nxt_state.hour   = set_value.hour;
            nxt_state.minute = set_value.minute;
            nxt_state.second = set_value.second;
         end
         REQ_SET_DATE: begin
            nxt_state.day   = set_value.day;
            nxt_state.month = set_value.month;
            nxt_state.year  = set_value.year;
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/tdcc_skid.sv =====
// Two-entry output buffer: result register plus skid register.
// Depends on tdcc_pkg.
module tdcc_skid (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [tdcc_pkg::DataWidth-1:0]   in_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [tdcc_pkg::DataWidth-1:0]   out_data
);
   import tdcc_pkg::*;

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   logic [DataWidth-1:0] main_ff;
   logic [DataWidth-1:0] skid_ff;
   logic                 push;
   logic                 main_free;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign main_free = !main_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (push) begin
         skid_ff <= in_data;
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule
